[hw/rtl/spsu_pkg.sv]
// shared types and constants for the sieve totient and divisor-sum unit
package spsu_pkg;

    localparam int unsigned QUERY_W = 16;
    localparam int unsigned PHI_W   = 16;
    localparam int unsigned SIGMA_W = 19;

    localparam logic [PHI_W-1:0]   PHI_MAX   = '1;
    localparam logic [SIGMA_W-1:0] SIGMA_MAX = '1;

    typedef enum logic [1:0] {
        t_sv_outer,
        t_sv_mark,
        t_sv_done
    } t_sieve_state;

    typedef enum logic [3:0] {
        t_fc_wait,
        t_fc_idle,
        t_fc_rd,
        t_fc_fetch,
        t_fc_div,
        t_fc_mul_phi,
        t_fc_mul_sig,
        t_fc_result
    } t_fact_state;

    // read request to the factor table
    typedef struct packed {
        logic        rd_en;
        logic [19:0] rd_addr;
    } t_tbl_rd;

endpackage

[hw/rtl/spsu_sieve.sv]
// linear sieve that fills the smallest-prime-factor table after reset
module spsu_sieve #(
    parameter int unsigned TABLE_SIZE = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    output logic                           o_done,
    output logic                           o_wr_en,
    output logic [$clog2(TABLE_SIZE)-1:0]  o_wr_addr,
    output logic [$clog2(TABLE_SIZE)-1:0]  o_wr_data,
    output logic                           o_rd_en,
    output logic [$clog2(TABLE_SIZE)-1:0]  o_rd_addr,
    input  logic [$clog2(TABLE_SIZE)-1:0]  i_rd_data
);
    import spsu_pkg::*;

    localparam int unsigned AW    = $clog2(TABLE_SIZE);
    localparam int unsigned DEPTH = TABLE_SIZE / 8 + 64;
    localparam int unsigned PW    = $clog2(DEPTH + 1);
    localparam int unsigned SW    = $clog2(DEPTH);

    // prime list, read through a register
    logic [AW-1:0] r_primes [DEPTH];
    logic [AW-1:0] r_p_rd;

    t_sieve_state r_state, n_state;
    logic [AW:0]   r_i, n_i;
    logic [PW-1:0] r_total, n_total;
    logic [PW-1:0] r_j, n_j;
    logic [AW-1:0] r_spf, n_spf;
    logic          r_phase, n_phase;  // 0: read spf, 1: spf valid
    logic          r_p_vld, n_p_vld;
    logic          p_wr;
    logic [SW-1:0] p_wr_addr;
    logic [AW-1:0] p_wr_data;
    logic          p_rd;
    logic [2*AW+1:0] prod;

    // unmarked entries must read as zero, so a clearing pass over the
    // whole table runs before the sieve starts
    logic          r_clear;
    logic [AW:0]   r_clr_addr;

    assign prod = {{(AW+1){1'b0}}, r_i} * {{(AW+2){1'b0}}, r_p_rd};

    always_ff @(posedge i_clk) begin
        if (p_wr) r_primes[p_wr_addr] <= p_wr_data;
        if (p_rd) r_p_rd <= r_primes[r_j[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= t_sv_outer;
            r_i        <= (AW+1)'(2);
            r_total    <= '0;
            r_j        <= '0;
            r_spf      <= '0;
            r_phase    <= 1'b0;
            r_p_vld    <= 1'b0;
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == (AW+1)'(TABLE_SIZE - 1)) r_clear <= 1'b0;
            end else begin
                r_state <= n_state;
                r_i     <= n_i;
                r_total <= n_total;
                r_j     <= n_j;
                r_spf   <= n_spf;
                r_phase <= n_phase;
                r_p_vld <= n_p_vld;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_sv_outer: begin
                if (r_i >= (AW+1)'(TABLE_SIZE)) n_state = t_sv_done;
                else if (r_phase) n_state = t_sv_mark;
            end
            t_sv_mark: begin
                if (!r_p_vld) begin
                    if (r_j >= r_total) n_state = t_sv_outer;
                end else if (r_p_rd > r_spf || prod >= (2*AW+2)'(TABLE_SIZE)) begin
                    n_state = t_sv_outer;
                end
            end
            t_sv_done: n_state = t_sv_done;
            default:   n_state = t_sv_done;
        endcase
    end

    always_comb begin
        n_i       = r_i;
        n_total   = r_total;
        n_j       = r_j;
        n_spf     = r_spf;
        n_phase   = r_phase;
        n_p_vld   = 1'b0;
        p_wr      = 1'b0;
        p_wr_addr = r_total[SW-1:0];
        p_wr_data = r_i[AW-1:0];
        p_rd      = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_i[AW-1:0];
        o_wr_data = r_i[AW-1:0];
        o_rd_en   = 1'b0;
        o_rd_addr = r_i[AW-1:0];
        if (r_clear) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_clr_addr[AW-1:0];
            o_wr_data = '0;
        end else begin
            unique case (r_state)
                t_sv_outer: begin
                    if (r_i >= (AW+1)'(TABLE_SIZE)) begin
                    end else if (!r_phase) begin
                        o_rd_en = 1'b1;
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        n_j     = '0;
                        if (i_rd_data == '0) begin
                            o_wr_en = 1'b1;
                            n_spf   = r_i[AW-1:0];
                            if (r_total < PW'(DEPTH)) begin
                                p_wr    = 1'b1;
                                n_total = r_total + 1'b1;
                            end
                        end else begin
                            n_spf = i_rd_data;
                        end
                    end
                end
                t_sv_mark: begin
                    // alternate: fetch prime j, then test and mark
                    if (!r_p_vld) begin
                        if (r_j >= r_total) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            p_rd    = 1'b1;
                            n_p_vld = 1'b1;
                        end
                    end else begin
                        if (r_p_rd > r_spf || prod >= (2*AW+2)'(TABLE_SIZE)) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = prod[AW-1:0];
                            o_wr_data = r_p_rd;
                            n_j       = r_j + 1'b1;
                        end
                    end
                end
                t_sv_done: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = !r_clear && (r_state == t_sv_done);

endmodule

[hw/rtl/spsu_factor.sv]
// query engine: factors n through the table one prime power at a time
module spsu_factor #(
    parameter int unsigned TABLE_SIZE = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ready_tbl,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [spsu_pkg::QUERY_W-1:0]   i_query,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [spsu_pkg::PHI_W-1:0]     o_phi,
    output logic [spsu_pkg::SIGMA_W-1:0]   o_sigma,
    output logic [spsu_pkg::QUERY_W-1:0]   o_least,
    output logic                           o_prime,
    output logic                           o_range,
    output logic                           o_rd_en,
    output logic [$clog2(TABLE_SIZE)-1:0]  o_rd_addr,
    input  logic [$clog2(TABLE_SIZE)-1:0]  i_rd_data
);
    import spsu_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SIZE);

    t_fact_state r_state, n_state;
    logic [QUERY_W-1:0] r_rest, r_p, r_q, r_pe, r_pe_prev;
    logic [SIGMA_W:0]   r_part;
    logic [PHI_W-1:0]   r_phi;
    logic [SIGMA_W-1:0] r_sig;
    logic [QUERY_W-1:0] r_least;
    logic               r_prime, r_range, r_first;
    logic [QUERY_W-1:0] r_n;
    logic [4:0]         r_bit;
    logic [QUERY_W-1:0] r_rem;
    logic               r_o_vld;
    logic [PHI_W-1:0]   r_o_phi;
    logic [SIGMA_W-1:0] r_o_sig;
    logic [QUERY_W-1:0] r_o_least;
    logic               r_o_prime, r_o_range;
    logic [QUERY_W:0]   trial;
    logic               sub_ok;
    logic [QUERY_W-1:0] rem_nx;
    logic [QUERY_W-1:0] q_nx;
    logic [QUERY_W-1:0] pm1;
    logic [2*QUERY_W-1:0] pe_mul;
    logic [2*QUERY_W-1:0] mphi;
    logic [SIGMA_W+SIGMA_W:0] msig;
    logic               out_rng;
    logic               res_load;

    assign out_rng = (i_query == '0) ||
                     ({{(AW+1){1'b0}}, i_query} >= (QUERY_W+AW+1)'(TABLE_SIZE));
    assign trial  = {r_rem, r_rest[r_bit[3:0]]};
    assign sub_ok = (trial >= {1'b0, r_p});
    assign rem_nx = sub_ok ? QUERY_W'(trial - {1'b0, r_p}) : trial[QUERY_W-1:0];
    assign q_nx   = sub_ok ? (r_q | (QUERY_W'(1) << r_bit[3:0])) : r_q;
    assign pe_mul = {{QUERY_W{1'b0}}, r_pe} * {{QUERY_W{1'b0}}, r_p};
    assign pm1    = r_p - 1'b1;
    assign mphi   = r_phi * ((r_first) ? pm1 : r_pe_prev);
    assign msig   = {{(SIGMA_W+1){1'b0}}, r_sig} * {{SIGMA_W{1'b0}}, r_part};
    // result moves to the output register once that is free or being read
    assign res_load = (r_state == t_fc_result) && (!r_o_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_fc_wait;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_fc_wait:    if (i_ready_tbl) n_state = t_fc_idle;
            t_fc_idle: begin
                if (i_in_valid) begin
                    if (out_rng || i_query == QUERY_W'(1)) n_state = t_fc_result;
                    else n_state = t_fc_rd;
                end
            end
            t_fc_rd:      n_state = t_fc_fetch;
            t_fc_fetch:   n_state = t_fc_div;
            t_fc_div: begin
                if (r_bit == '0 && rem_nx != '0) n_state = t_fc_mul_phi;
            end
            t_fc_mul_phi: n_state = t_fc_mul_sig;
            t_fc_mul_sig: n_state = (r_rest > QUERY_W'(1)) ? t_fc_rd : t_fc_result;
            t_fc_result:  if (!r_o_vld || i_out_ready) n_state = t_fc_idle;
            default:      n_state = t_fc_idle;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == t_fc_idle);
        o_out_valid = r_o_vld;
        o_rd_en     = (r_state == t_fc_rd);
        o_rd_addr   = AW'(r_rest);
    end

    // bit-serial division of rest by p; a zero remainder divides out one more p
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            t_fc_idle: begin
                r_n     <= i_query;
                r_rest  <= i_query;
                r_phi   <= PHI_W'(1);
                r_sig   <= SIGMA_W'(1);
                r_least <= '0;
                r_prime <= 1'b0;
                r_range <= out_rng;
                r_first <= 1'b1;
            end
            t_fc_fetch: begin
                r_p       <= QUERY_W'(i_rd_data);
                r_pe      <= QUERY_W'(1);
                r_pe_prev <= QUERY_W'(1);
                r_part    <= (SIGMA_W+1)'(1);
                r_bit     <= 5'(QUERY_W - 1);
                r_rem     <= '0;
                r_q       <= '0;
                r_first   <= 1'b1;
                if (r_rest == r_n) begin
                    r_least <= QUERY_W'(i_rd_data);
                    r_prime <= (QUERY_W'(i_rd_data) == r_n);
                end
            end
            t_fc_div: begin
                if (r_bit != '0) begin
                    r_rem <= rem_nx;
                    r_q   <= q_nx;
                    r_bit <= r_bit - 1'b1;
                end else if (rem_nx == '0) begin
                    // exact division: take quotient and restart
                    r_rest    <= q_nx;
                    r_pe_prev <= r_pe;
                    r_pe      <= pe_mul[QUERY_W-1:0];
                    r_part    <= r_part + (SIGMA_W+1)'(pe_mul);
                    r_bit     <= 5'(QUERY_W - 1);
                    r_rem     <= '0;
                    r_q       <= '0;
                end
            end
            t_fc_mul_phi: begin
                // phi *= (p-1) first, then p^(e-1) on a second pass
                if (mphi > {{PHI_W{1'b0}}, PHI_MAX}) r_phi <= PHI_MAX;
                else r_phi <= mphi[PHI_W-1:0];
                r_first <= 1'b0;
            end
            t_fc_mul_sig: begin
                if (mphi > {{PHI_W{1'b0}}, PHI_MAX}) r_phi <= PHI_MAX;
                else r_phi <= mphi[PHI_W-1:0];
                if (msig > {{(SIGMA_W+1){1'b0}}, SIGMA_MAX}) r_sig <= SIGMA_MAX;
                else r_sig <= msig[SIGMA_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_o_vld <= 1'b0;
        else if (res_load)    r_o_vld <= 1'b1;
        else if (i_out_ready) r_o_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o_phi   <= r_range ? '0 : r_phi;
            r_o_sig   <= r_range ? '0 : r_sig;
            r_o_least <= r_range ? '0 : r_least;
            r_o_prime <= r_range ? 1'b0 : r_prime;
            r_o_range <= r_range;
        end
    end

    always_comb begin
        o_phi   = r_o_phi;
        o_sigma = r_o_sig;
        o_least = r_o_least;
        o_prime = r_o_prime;
        o_range = r_o_range;
    end

endmodule

[hw/rtl/sieve_phi_sigma_unit_top.sv]
// top level: factor table memory, sieve fill and query engine
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | query_number[15:0]                                 | -
//  m_axis  | out | totient[15:0] divisor_sum[34:16] least_factor[50:35]| prime_flag, range_error
//
// after reset the sieve clears the table, then fills it; no query is taken
// until then. a query of one or out of range goes straight to the result
// beat; else each prime power p^e of n takes a table read, bit-serial trial
// divisions with one failing trial per prime, and the phi and sigma updates.
// the result beat waits in an output register, so the next query is taken
// meanwhile; the input stalls while a query is being factored and while a
// second result waits behind it.
module sieve_phi_sigma_unit_top #(
    parameter int unsigned TABLE_SIZE = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // query_number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // totient, divisor_sum, least_factor, zero fill
    output logic [1:0]  m_axis_tuser    // prime_flag, range_error
);
    import spsu_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SIZE);

    logic [AW-1:0] r_tbl [TABLE_SIZE];
    logic [AW-1:0] r_rd_data;

    logic          sv_done, sv_wr, sv_rd, fc_rd;
    logic [AW-1:0] sv_wa, sv_wd, sv_ra, fc_ra;
    logic [PHI_W-1:0]   phi;
    logic [SIGMA_W-1:0] sig;
    logic [QUERY_W-1:0] least;
    logic prime, rng;

    always_ff @(posedge i_clk) begin
        if (sv_wr) r_tbl[sv_wa] <= sv_wd;
        if (sv_rd || fc_rd) r_rd_data <= r_tbl[sv_done ? fc_ra : sv_ra];
    end

    spsu_sieve #(.TABLE_SIZE(TABLE_SIZE)) u_sieve (
        .i_clk, .i_rst_n,
        .o_done(sv_done), .o_wr_en(sv_wr), .o_wr_addr(sv_wa), .o_wr_data(sv_wd),
        .o_rd_en(sv_rd), .o_rd_addr(sv_ra), .i_rd_data(r_rd_data)
    );

    spsu_factor #(.TABLE_SIZE(TABLE_SIZE)) u_factor (
        .i_clk, .i_rst_n, .i_ready_tbl(sv_done),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready), .i_query(s_axis_tdata),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_phi(phi), .o_sigma(sig), .o_least(least), .o_prime(prime), .o_range(rng),
        .o_rd_en(fc_rd), .o_rd_addr(fc_ra), .i_rd_data(r_rd_data)
    );

    assign m_axis_tdata = {5'd0, least, sig, phi};
    assign m_axis_tuser = {rng, prime};

endmodule
